[rtl/slt_pkg.sv]
// Shared constants and types for the sorted list table.
package slt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   localparam int VAL_W    = 32;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 4;
   localparam int CNT_W    = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

   // per-beat command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctl_type;

   // compare results reported by a cell
   typedef struct packed {
      logic lt;    // holds a value below the request
      logic bnd;   // first cell not below the request
      logic hit;   // boundary cell holds an equal value
   } cell_stat_type;

endpackage

[rtl/slt_cell.sv]
// One storage cell of the sorted row: compare against the request, shift on insert or remove.
module slt_cell (
   input  logic                       clock,
   input  slt_pkg::cell_ctl_type      ctl,
   input  logic [slt_pkg::VAL_W-1:0]  value,
   input  logic                       valid,
   input  logic                       prev_lt,
   input  logic [slt_pkg::VAL_W-1:0]  left_entry,
   input  logic [slt_pkg::VAL_W-1:0]  right_entry,
   output logic [slt_pkg::VAL_W-1:0]  entry,
   output slt_pkg::cell_stat_type     stat
);
   import slt_pkg::*;

   logic [VAL_W-1:0] entry_ff;
   logic [VAL_W-1:0] entry_in;
   logic             lt;
   logic             bnd;

   assign lt  = valid && ($signed(entry_ff) < $signed(value));
   assign bnd = !lt && prev_lt;

   assign stat.lt  = lt;
   assign stat.bnd = bnd;
   assign stat.hit = bnd && valid && (entry_ff == value);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins && !lt) begin
         entry_in = bnd ? value : left_entry;
      end else if (ctl.rem && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/sorted_list_table.sv]
// Top level of the sorted list table: cell row, count and response register.
// The response is registered: it is loaded, with its valid, at the edge that accepts the request.
// Throughput: one request per cycle unless stalled; each cell compares and shifts in that cycle.
// A response waiting for rsp_tready holds req_tready low until that beat is taken.
// Reset (synchronous, active high) empties the table and drops the response valid;
// the cell contents are not cleared, only entries below the count are ever read.
module sorted_list_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [slt_pkg::REQ_DATA_W-1:0]  req_tdata,  // op[1:0], value[33:2], zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [slt_pkg::RSP_DATA_W-1:0]  rsp_tdata   // status[1:0], position[5:2], count[10:6]
);
   import slt_pkg::*;

   logic                 accept;
   logic [OP_W-1:0]      op;
   logic [VAL_W-1:0]     value;
   logic                 full;
   logic                 match;
   logic [IDX_W-1:0]     at_idx;
   cell_ctl_type         ctl;

   logic [VAL_W-1:0]     entry_w [CAPACITY];
   cell_stat_type        stat_w  [CAPACITY];
   logic [CAPACITY-1:0]  hit_v;

   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STAT_W-1:0]    status;
   logic [IDX_W-1:0]     pos;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tdata[OP_W-1:0];
   assign value      = req_tdata[OP_W +: VAL_W];
   assign full       = (fill_ff == FILL_W'(CAPACITY));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 prev_lt;
      logic [VAL_W-1:0]     left_entry;
      logic [VAL_W-1:0]     right_entry;

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign left_entry = value;
      end else begin : g_mid
         assign prev_lt    = stat_w[i-1].lt;
         assign left_entry = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_nlast
         assign right_entry = entry_w[i+1];
      end

      slt_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value       (value),
         .valid       (fill_ff > FILL_W'(i)),
         .prev_lt     (prev_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .stat        (stat_w[i])
      );

      assign hit_v[i] = stat_w[i].hit;
   end

   assign match = |hit_v;

   // boundary is one-hot (or absent when full and every entry is below)
   always_comb begin
      at_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (stat_w[i].bnd) begin
            at_idx = at_idx | IDX_W'(i);
         end
      end
   end

   assign ctl.ins = accept && (op == OP_INSERT) && !full;
   assign ctl.rem = accept && (op == OP_REMOVE) && match;

   always_comb begin
      fill_in = fill_ff;
      status  = ST_MISSING;
      pos     = '0;
      unique case (op)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               status  = ST_OK;
               pos     = at_idx;
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         OP_REMOVE: begin
            if (match) begin
               status  = ST_OK;
               pos     = at_idx;
               fill_in = fill_ff - FILL_W'(1);
            end
         end
         OP_SEARCH: begin
            if (match) begin
               status = ST_OK;
               pos    = at_idx;
            end
         end
         default: begin
            status = ST_MISSING;
         end
      endcase
      rsp_data_in = {5'd0, CNT_W'(fill_in), POS_W'(pos), status};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CAPACITY))
      else $error("fill beyond capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_INSERT) && !full) |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("insert did not grow the table");

   a_fail_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[STAT_W-1:0] != ST_OK))
         |-> (rsp_data_ff[STAT_W +: POS_W] == '0))
      else $error("failed beat carries a position");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[STAT_W-1:0] == ST_FULL))
         |-> (rsp_data_ff[STAT_W+POS_W +: CNT_W] == CNT_W'(CAPACITY)))
      else $error("full reject with wrong count");

endmodule

[sim/tb_sorted_list_table.sv]
// Self-checking testbench for the sorted list table: directed and random requests.
`timescale 1ns / 100ps

module tb_sorted_list_table;
   import slt_pkg::*;

   localparam int  N_RANDOM   = 2000;
   localparam int  HOLD_LEN   = 300;
   localparam int  GRACE      = 10;
   localparam longint LIMIT   = 200000;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused operation code

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [CNT_W-1:0]  count;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // op[1:0], value[33:2], zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // status[1:0], position[5:2], count[10:6]

   sorted_list_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   logic [REQ_DATA_W-1:0] pending_reqs[$];
   outcome_type           expected_rsps[$];
   int                    total_reqs = 0;
   int                    issued     = 0;
   int                    accepted   = 0;
   int                    errors     = 0;
   longint                cycles     = 0;
   int                    hold_left  = 0;
   bit                    hold_done  = 1'b0;

   // shadow of the table contents
   logic signed [VAL_W-1:0] shadow_vals[CAPACITY];
   int                      shadow_fill = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // --- prediction ---------------------------------------------------------

   function automatic int locate_first(logic signed [VAL_W-1:0] v);
      int at;
      at = 0;
      while (at < shadow_fill && shadow_vals[at] < v) at++;
      if (at < shadow_fill && shadow_vals[at] == v) return at;
      return -1;
   endfunction

   function automatic outcome_type apply_request(logic [OP_W-1:0] op,
                                                 logic signed [VAL_W-1:0] v);
      outcome_type r;
      int          at;
      r.status   = ST_MISSING;
      r.position = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               at = 0;
               while (at < shadow_fill && shadow_vals[at] < v) at++;
               for (int i = shadow_fill; i > at; i--) shadow_vals[i] = shadow_vals[i-1];
               shadow_vals[at] = v;
               shadow_fill++;
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         OP_REMOVE: begin
            at = locate_first(v);
            if (at >= 0) begin
               for (int i = at; i + 1 < shadow_fill; i++) shadow_vals[i] = shadow_vals[i+1];
               shadow_fill--;
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         OP_SEARCH: begin
            at = locate_first(v);
            if (at >= 0) begin
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         default: ;
      endcase
      r.count = shadow_fill[CNT_W-1:0];
      return r;
   endfunction

   // --- stimulus -----------------------------------------------------------

   task automatic queue_req(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v);
      pending_reqs.push_back({{(REQ_DATA_W-VAL_W-OP_W){1'b0}}, v, op});
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $signed($urandom_range(12)) - 6;
      if (sel < 70) begin
         case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0001;
            3: return 32'sh7fff_fffe;
            4: return 0;
            default: return -1;
         endcase
      end
      return $signed($urandom());
   endfunction

   function automatic logic [OP_W-1:0] pick_op(bit grow);
      int sel;
      sel = $urandom_range(99);
      if (sel < 3) return OP_SPARE;
      if (grow) begin
         if (sel < 68) return OP_INSERT;
         if (sel < 88) return OP_REMOVE;
         return OP_SEARCH;
      end
      if (sel < 28) return OP_INSERT;
      if (sel < 78) return OP_REMOVE;
      return OP_SEARCH;
   endfunction

   // --- idling per phase ---------------------------------------------------

   function automatic int send_idle_pct(int n);
      if (n < total_reqs / 3) return 21;
      if (n < 2 * total_reqs / 3) return 60;
      return 0;
   endfunction

   function automatic int recv_idle_pct(int n);
      if (n < total_reqs / 3) return 60;
      if (n < 2 * total_reqs / 3) return 21;
      return 0;
   endfunction

   // --- driver -------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct(issued)) begin
            req_tdata  <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            issued     <= issued + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once the last phase starts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && issued >= 2 * total_reqs / 3) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct(issued));
      end
   end

   // --- monitor ------------------------------------------------------------

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset) begin
         // a response always belongs to an earlier request beat, so check first
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[1:0];
            got.position = rsp_tdata[5:2];
            got.count    = rsp_tdata[10:6];
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat, got status %0d position %0d count %0d",
                        $time, got.status, got.position, got.count);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.position !== want.position) begin
                  $display("%0t: position mismatch, expected %0d actual %0d",
                           $time, want.position, got.position);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: count mismatch, expected %0d actual %0d",
                           $time, want.count, got.count);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_request(req_tdata[OP_W-1:0],
                                                  $signed(req_tdata[OP_W+VAL_W-1:OP_W])));
            accepted <= accepted + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // --- sequence -----------------------------------------------------------

   initial begin
      bit grow;
      // directed: extremes, duplicates, misses, unused code, then fill to full
      queue_req(OP_INSERT, 32'sh7fff_ffff);
      queue_req(OP_INSERT, 32'sh8000_0000);
      queue_req(OP_INSERT, 0);
      queue_req(OP_INSERT, 0);
      queue_req(OP_INSERT, -1);
      queue_req(OP_SEARCH, 0);
      queue_req(OP_SEARCH, 5);
      queue_req(OP_REMOVE, 0);
      queue_req(OP_REMOVE, 7);
      queue_req(OP_SPARE, 32'sh7fff_ffff);
      for (int i = 0; i < 12; i++) queue_req(OP_INSERT, (i % 3 == 0) ? -i : i * 1000);
      queue_req(OP_INSERT, 42);                  // rejected, table full
      queue_req(OP_SEARCH, 32'sh7fff_ffff);      // last slot
      queue_req(OP_REMOVE, 32'sh8000_0000);      // first slot
      for (int k = 0; k < N_RANDOM; k++) begin
         grow = ((k / 48) % 2) == 0;
         queue_req(pick_op(grow), pick_value());
      end
      total_reqs = pending_reqs.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_reqs) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (GRACE) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
